// File: src/rsmba_pkg.sv
package rsmba_pkg;

  // field and register widths
  localparam int CRD_W   = 10;
  localparam int DIM_W   = 9;
  localparam int SCALE_W = 10;
  localparam int CODE_W  = 16;
  localparam int VAL_W   = 24;
  localparam int HALF_W  = 4;
  localparam int CNT_W   = 10;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 2;

  // default sizes
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_HALF   = 15;

  // register reset values
  localparam logic [DIM_W-1:0]   RST_WIDTH  = DIM_W'(256);
  localparam logic [DIM_W-1:0]   RST_HEIGHT = DIM_W'(256);
  localparam logic [SCALE_W-1:0] RST_SCALE  = SCALE_W'(10);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RASTER_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RASTER_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 2'd2;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // code limits
  localparam int NO_DATA_CODE = -32383;
  localparam int RAW_LIMIT    = -32381;
  localparam int CODE_MAX     = 32767;

  localparam logic signed [CODE_W-1:0] NO_DATA_C   = CODE_W'(NO_DATA_CODE);
  localparam logic signed [CODE_W-1:0] RAW_LIMIT_C = CODE_W'(RAW_LIMIT);
  localparam logic signed [VAL_W-1:0]  NO_DATA_Q8  = VAL_W'(NO_DATA_CODE * 256);
  localparam logic signed [VAL_W-1:0]  RAW_LIMIT_Q8 = VAL_W'(RAW_LIMIT * 256);
  localparam logic signed [VAL_W-1:0]  VAL_MIN     = VAL_W'(-8388608);

  typedef struct packed {
    logic                     operation;
    logic [7:0]               col;
    logic [7:0]               row;
    logic signed [VAL_W-1:0]  write_value;
    logic [HALF_W-1:0]        window_half;
  } in_item_t;

  typedef struct packed {
    logic                     status;
    logic signed [VAL_W-1:0]  read_value;
    logic signed [CODE_W-1:0] stored_code;
    logic                     is_no_data;
    logic [CNT_W-1:0]         valid_count;
  } out_item_t;

endpackage

// File: src/raster_store_masked_box_average.sv
// Raster store with masked box-average reads. After reset the block clears its store to the
// no-data marker, all MAX_WIDTH*MAX_HEIGHT cells (65536 by default), with in_stall
// high; configuration writes are taken meanwhile. One item is handled at a time under a small
// sequencer around one shared multiplier, a single-port store and a one-bit-per-cycle divider.
// A window read reads one cell per cycle from the store port over the clipped window area (up
// to 961 cells), then divides for the average over DVW quotient bits (34 by default).
module raster_store_masked_box_average #(
  parameter int MAX_WIDTH  = rsmba_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rsmba_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_HALF   = rsmba_pkg::DEF_MAX_HALF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rsmba_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rsmba_pkg::out_item_t               out_data,
  input  logic                               cfg_we,
  input  logic [rsmba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsmba_pkg::CFG_W-1:0]        cfg_wdata
);
  import rsmba_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIN   = 2 * MAX_HALF + 1;
  localparam int NW    = $clog2(WIN * WIN + 1);
  localparam int SW    = NW + CODE_W;
  localparam int DVW   = SW + 8;
  localparam int DSW   = NW + SCALE_W;
  localparam int MA_W  = (NW + 1 > VAL_W + 1) ? NW + 1 : VAL_W + 1;
  localparam int MB_W  = SCALE_W + 1;
  localparam int MP_W  = MA_W + MB_W;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_CHECK = 13'b0000000000100,
    S_ADDR  = 13'b0000000001000,
    S_QUANT = 13'b0000000010000,
    S_CRD   = 13'b0000000100000,
    S_ROWB  = 13'b0000001000000,
    S_SCAN  = 13'b0000010000000,
    S_DRAIN = 13'b0000100000000,
    S_CNT   = 13'b0001000000000,
    S_DIVS  = 13'b0010000000000,
    S_DIVW  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            clr_r, clr_nxt;
  logic [DIM_W-1:0]         width_r, width_nxt;
  logic [DIM_W-1:0]         height_r, height_nxt;
  logic [SCALE_W-1:0]       scale_r, scale_nxt;
  in_item_t                 item_r, item_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [AW-1:0]            row_base_r, row_base_nxt;
  logic [CRD_W-1:0]         x_r, x_nxt, y_r, y_nxt;
  logic [CRD_W-1:0]         x0_r, x0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  logic signed [MP_W-1:0]   mul_r, mul_nxt;
  logic signed [SW-1:0]     sum_r, sum_nxt;
  logic [NW-1:0]            cnt_r, cnt_nxt;
  logic                     pend_r, pend_nxt;
  out_item_t                res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic [CRD_W-1:0]         wd, ht;
  logic [SCALE_W-1:0]       scale_eff;
  logic [HALF_W-1:0]        half_clamp;
  logic [CRD_W-1:0]         col_c, row_c, half_c;
  logic [CRD_W-1:0]         win_x0, win_x1, win_y0, win_y1;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic                     mem_we;
  logic [AW-1:0]            mem_addr;
  logic signed [CODE_W-1:0] mem_wdata;
  logic signed [CODE_W-1:0] mem_rdata;
  logic signed [VAL_W:0]    w_rnd;
  logic signed [MP_W-1:0]   ws_rnd;
  logic                     raw_ok, scaled_ok;
  logic signed [CODE_W-1:0] q_code;
  logic                     div_start, div_busy, div_done;
  logic signed [DVW-1:0]    div_quot;

  // effective configuration
  assign wd = (int'(width_r) > MAX_WIDTH) ? CRD_W'(MAX_WIDTH) : CRD_W'(width_r);
  assign ht = (int'(height_r) > MAX_HEIGHT) ? CRD_W'(MAX_HEIGHT) : CRD_W'(height_r);
  assign scale_eff = (scale_r == '0) ? SCALE_W'(1) : scale_r;
  assign half_clamp = (int'(in_data.window_half) > MAX_HALF) ? HALF_W'(MAX_HALF)
                                                             : in_data.window_half;

  // clipped window bounds around the centre
  assign col_c  = CRD_W'(item_r.col);
  assign row_c  = CRD_W'(item_r.row);
  assign half_c = CRD_W'(item_r.window_half);
  assign win_x0 = (col_c < half_c) ? '0 : col_c - half_c;
  assign win_y0 = (row_c < half_c) ? '0 : row_c - half_c;
  assign win_x1 = (col_c + half_c >= wd) ? wd - CRD_W'(1) : col_c + half_c;
  assign win_y1 = (row_c + half_c >= ht) ? ht - CRD_W'(1) : row_c + half_c;

  // write quantization, truncating toward zero
  assign w_rnd  = (VAL_W + 1)'(item_r.write_value)
                + (item_r.write_value[VAL_W-1] ? (VAL_W + 1)'(255) : '0);
  assign ws_rnd = mul_r + (mul_r[MP_W-1] ? MP_W'(255) : '0);
  assign raw_ok = (item_r.write_value != VAL_MIN) && (item_r.write_value <= RAW_LIMIT_Q8);
  assign scaled_ok = (mul_r > MP_W'(RAW_LIMIT * 256)) && (mul_r <= MP_W'(CODE_MAX * 256));
  assign q_code = raw_ok ? w_rnd[8 +: CODE_W] : scaled_ok ? ws_rnd[8 +: CODE_W] : NO_DATA_C;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_CHECK: begin
        mul_a = MA_W'(row_c);
        mul_b = MB_W'(wd);
      end
      S_ADDR: begin
        mul_a = MA_W'(item_r.write_value);
        mul_b = MB_W'(scale_eff);
      end
      S_CRD: begin
        mul_a = MA_W'(win_y0);
        mul_b = MB_W'(wd);
      end
      S_CNT: begin
        mul_a = MA_W'(cnt_r);
        mul_b = MB_W'(scale_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_nxt = MP_W'(mul_a) * MP_W'(mul_b);
  end

  // store port
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = q_code;
    mem_addr  = addr_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = NO_DATA_C;
        mem_addr  = clr_r;
      end
      S_ADDR:  mem_addr = AW'(mul_r) + AW'(item_r.col);
      S_QUANT: mem_we = 1'b1;
      S_SCAN:  mem_addr = row_base_r + AW'(x_r);
      default: mem_addr = addr_r;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    item_nxt      = item_r;
    addr_nxt      = addr_r;
    row_base_nxt  = row_base_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    pend_nxt      = (state_r == S_SCAN);
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    // accumulate the cell whose address was given in the previous cycle
    if (pend_r && (mem_rdata > RAW_LIMIT_C)) begin
      sum_nxt = sum_r + SW'(mem_rdata);
      cnt_nxt = cnt_r + NW'(1);
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt             = in_data;
          item_nxt.window_half = half_clamp;
          state_nxt            = S_CHECK;
        end
      end
      S_CHECK: begin
        if (col_c >= wd || row_c >= ht) begin
          res_nxt        = '0;
          res_nxt.status = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        addr_nxt  = mem_addr;
        state_nxt = (item_r.operation == OP_WRITE) ? S_QUANT : S_CRD;
      end
      S_QUANT: begin
        res_nxt            = '0;
        res_nxt.stored_code = q_code;
        res_nxt.is_no_data = (q_code <= RAW_LIMIT_C);
        state_nxt          = S_FIN;
      end
      S_CRD: begin
        res_nxt             = '0;
        res_nxt.stored_code = mem_rdata;
        if (item_r.window_half < HALF_W'(2)) begin
          if (mem_rdata > RAW_LIMIT_C) begin
            sum_nxt   = SW'(mem_rdata);
            cnt_nxt   = NW'(1);
            state_nxt = S_CNT;
          end else begin
            res_nxt.read_value = {mem_rdata, 8'b0};
            res_nxt.is_no_data = 1'b1;
            state_nxt          = S_FIN;
          end
        end else begin
          sum_nxt   = '0;
          cnt_nxt   = '0;
          x0_nxt    = win_x0;
          x1_nxt    = win_x1;
          y1_nxt    = win_y1;
          x_nxt     = win_x0;
          y_nxt     = win_y0;
          state_nxt = S_ROWB;
        end
      end
      S_ROWB: begin
        row_base_nxt = AW'(mul_r);
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        if (x_r == x1_r) begin
          x_nxt = x0_r;
          if (y_r == y1_r) begin
            state_nxt = S_DRAIN;
          end else begin
            y_nxt        = y_r + CRD_W'(1);
            row_base_nxt = row_base_r + AW'(wd);
          end
        end else begin
          x_nxt = x_r + CRD_W'(1);
        end
      end
      S_DRAIN: state_nxt = S_CNT;
      S_CNT: begin
        if (cnt_r == '0) begin
          res_nxt.read_value = NO_DATA_Q8;
          res_nxt.is_no_data = 1'b1;
          state_nxt          = S_FIN;
        end else begin
          state_nxt = S_DIVS;
        end
      end
      S_DIVS: begin
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          res_nxt.read_value  = div_quot[VAL_W-1:0];
          res_nxt.valid_count = CNT_W'(cnt_r);
          state_nxt           = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    scale_nxt  = scale_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RASTER_WIDTH:  width_nxt  = cfg_wdata[DIM_W-1:0];
        CFG_RASTER_HEIGHT: height_nxt = cfg_wdata[DIM_W-1:0];
        CFG_SCALE_FACTOR:  scale_nxt  = cfg_wdata[SCALE_W-1:0];
        default:           width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      width_r     <= RST_WIDTH;
      height_r    <= RST_HEIGHT;
      scale_r     <= RST_SCALE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      scale_r     <= scale_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    addr_r     <= addr_nxt;
    row_base_r <= row_base_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    mul_r      <= mul_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // raster store
  rsmba_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rd_data (mem_rdata)
  );

  // divider for the average
  rsmba_div #(
    .DVW (DVW),
    .DSW (DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_r, 8'b0}),
    .divisor  (DSW'(mul_r)),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // divider only started when idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  // outside coordinates give zero result fields
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |->
      (out_data.read_value == '0 && out_data.stored_code == '0 &&
       out_data.valid_count == '0 && !out_data.is_no_data))
    else $error("outside result carries data");

  // no-data results never report valid cells
  a_nodata_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_no_data) |-> (out_data.valid_count == '0))
    else $error("no-data result with nonzero count");

  // store written only while clearing or on a cell write
  a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_QUANT))
    else $error("unexpected store write");
`endif

endmodule

// File: src/rsmba_mem.sv
module rsmba_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [AW-1:0]                        addr,
  input  logic signed [rsmba_pkg::CODE_W-1:0] wdata,
  output logic signed [rsmba_pkg::CODE_W-1:0] rd_data
);
  import rsmba_pkg::*;

  logic signed [CODE_W-1:0] mem_r [DEPTH];

  // single port store, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rd_data <= mem_r[addr];
  end

endmodule

// File: src/rsmba_div.sv
module rsmba_div #(
  parameter int DVW = 30,
  parameter int DSW = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [DVW-1:0] dividend,
  input  logic [DSW-1:0]        divisor,
  output logic                  busy,
  output logic                  done,
  output logic signed [DVW-1:0] quotient
);
  import rsmba_pkg::*;

  localparam int CW = $clog2(DVW + 1);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic           neg_r, neg_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [DVW-1:0] n_r, n_nxt;
  logic [DSW-1:0] rem_r, rem_nxt;
  logic [DSW-1:0] d_r, d_nxt;
  logic [DSW:0]   trial;
  logic           fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial    = {rem_r, n_r[DVW-1]};
    fits     = trial >= {1'b0, d_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[DVW-1];
      n_nxt    = dividend[DVW-1] ? DVW'(-dividend) : DVW'(dividend);
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(DVW);
    end else if (busy_r) begin
      rem_nxt = fits ? DSW'(trial - {1'b0, d_r}) : DSW'(trial);
      n_nxt   = {n_r[DVW-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? -signed'(n_r) : signed'(n_r);

endmodule
